### sv/lfsa_pkg.sv
// Shared types and constants for the lowest-free slot allocator.
// Holds the request/response beat structs and the command and status codes.
// No dependencies.
`timescale 1ns / 1ps

package lfsa_pkg;

	localparam int SLOT_W    = 11;
	localparam int KIND_W    = 4;
	localparam int SLOTS_DEF = 1024;

	// Tag value that marks a slot as free
	localparam logic [KIND_W-1:0] FREE_TAG = '0;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_NEXT  = 2'd2,
		CMD_PREV  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] result_slot;
		status_t           status;
	} rsp_t;

endpackage

### sv/lfsa_tag_ram.sv
// Tag store of the slot allocator: one write port, one read port,
// read data registered. Uses lfsa_pkg for the tag width.
`timescale 1ns / 1ps

module lfsa_tag_ram
	import lfsa_pkg::*;
#(
	parameter int unsigned DEPTH = SLOTS_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [KIND_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [KIND_W-1:0] rdata
);

	logic [KIND_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/lowest_free_slot_allocator.sv
// Top level of the lowest-free slot allocator: sequencer, counters, scan logic.
// Depends on lfsa_pkg and lfsa_tag_ram.
`timescale 1ns / 1ps

// Usage
// Request channel req (valid/ready) carries one command beat: allocate, free,
// search next or search previous, with a tag and a slot/offset. Every request
// yields exactly one response beat on rsp (valid/ready): a slot number and a
// status (ok, table full, slot out of range).
// One request is handled at a time. After acceptance the block decodes the
// request, then scans the tag RAM where needed, one entry per cycle, with the
// read pipelined against the registered read port, then loads the response
// register. The single read port of the tag RAM sets the scan rate.
// req_ready is high whenever the sequencer is idle, so a new request can be
// taken while the previous response still waits in the output register; if
// the receiver stalls, a finished item waits in the sequencer until the
// output register frees up.
// Reset clears the used count, the lowest-free pointer and all valid flags.
// The tag RAM is not cleared: only slots below the used count are read, and
// those have always been written.

module lowest_free_slot_allocator
	import lfsa_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	localparam int AW = $clog2(SLOTS);
	// counters hold values up to SLOTS + 1
	localparam int CW = $clog2(SLOTS + 2);
	localparam int XW = (CW > SLOT_W) ? CW : SLOT_W;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     used_q;
	logic [CW-1:0]     lf_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;
	req_t              req_q;
	logic [CW-1:0]     res_q;
	status_t           stat_q;
	logic [CW-1:0]     p_q;
	logic              dir_up_q;
	logic              trim_q;
	logic [KIND_W-1:0] tgt_q;
	logic              rd_pend_s1;
	logic [CW-1:0]     rd_addr_s1;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [KIND_W-1:0] ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [KIND_W-1:0] ram_rdata;

	logic [XW-1:0]     slot_x;
	logic [XW-1:0]     used_x;
	logic [XW-1:0]     res_x;
	logic [CW-1:0]     slot_c;
	logic [CW-1:0]     off;
	logic [CW-1:0]     wsel;
	logic [CW-1:0]     pm1;
	logic [CW-1:0]     issue_addr;
	logic              lf_ge_used;
	logic              full;
	logic              slot_zero;
	logic              slot_oor;
	logic              slot_last;
	logic              can_issue;
	logic              hit;
	logic              rsp_load;

	// decode helpers
	assign slot_x     = XW'(req_q.slot);
	assign used_x     = XW'(used_q);
	assign slot_c     = slot_x[CW-1:0];
	assign off        = (slot_x < used_x) ? slot_c : used_q;
	assign lf_ge_used = lf_q >= used_q;
	assign full       = used_q == CW'(SLOTS);
	assign slot_zero  = req_q.slot == '0;
	assign slot_oor   = slot_x >= used_x;
	assign slot_last  = CW'(slot_c + CW'(1)) == used_q;

	// tag RAM write: allocate stores the tag, free clears the slot
	assign wsel      = (req_q.cmd == CMD_ALLOC) ? (lf_ge_used ? used_q : lf_q) : slot_c;
	assign ram_waddr = wsel[AW-1:0];
	assign ram_wdata = (req_q.cmd == CMD_ALLOC) ? req_q.kind : FREE_TAG;
	assign ram_we    = (state_q == ST_EXEC) &&
		(((req_q.cmd == CMD_ALLOC) && !(lf_ge_used && full)) ||
		 ((req_q.cmd == CMD_FREE) && !slot_zero && !slot_oor));

	// scan: one read issued per cycle, compare on the returning data
	assign pm1        = p_q - CW'(1);
	assign can_issue  = dir_up_q ? (p_q < used_q) : (p_q != '0);
	assign issue_addr = dir_up_q ? p_q : pm1;
	assign hit        = rd_pend_s1 && ((ram_rdata == tgt_q) != trim_q);
	assign ram_re     = (state_q == ST_SCAN) && !hit && can_issue;
	assign ram_raddr  = issue_addr[AW-1:0];

	// finishing step may load the response register once it is free
	assign rsp_load   = (state_q == ST_FIN) && (!rsp_valid_q || rsp_ready);

	lfsa_tag_ram #(
		.DEPTH(SLOTS)
	) u_tag_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// control: sequencer, used count, lowest-free pointer, valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			lf_q        <= '0;
			rsp_valid_q <= 1'b0;
			rd_pend_s1  <= 1'b0;
		end else begin
			// response beat: set on load, cleared once taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			rd_pend_s1 <= ram_re;
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (req_q.cmd)
						CMD_ALLOC: begin
							if (lf_ge_used) begin
								if (!full) begin
									used_q <= CW'(used_q + CW'(1));
									lf_q   <= CW'(used_q + CW'(1));
								end
								state_q <= ST_FIN;
							end else begin
								state_q <= ST_SCAN;
							end
						end
						CMD_FREE: begin
							if (slot_zero || slot_oor) begin
								state_q <= ST_FIN;
							end else begin
								if (slot_c < lf_q) begin
									lf_q <= slot_c;
								end
								if (slot_last) begin
									used_q  <= slot_c;
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_FIN;
								end
							end
						end
						CMD_NEXT, CMD_PREV: begin
							state_q <= ST_SCAN;
						end
						default: begin
							state_q <= ST_FIN;
						end
					endcase
				end
				ST_SCAN: begin
					// trimming: each free slot read pulls the count down
					if (trim_q && rd_pend_s1 && !hit) begin
						used_q <= rd_addr_s1;
					end
					if (hit) begin
						if (req_q.cmd == CMD_ALLOC) begin
							lf_q <= rd_addr_s1;
						end
						state_q <= ST_FIN;
					end else if (!can_issue) begin
						if (req_q.cmd == CMD_ALLOC) begin
							lf_q <= used_q;
						end
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (rsp_load) begin
						// pointer never left above the count after a free
						if ((req_q.cmd == CMD_FREE) && (lf_q > used_q)) begin
							lf_q <= used_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: captured request, result, scan pointer and mode
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					req_q <= req;
				end
			end
			ST_EXEC: begin
				unique case (req_q.cmd)
					CMD_ALLOC: begin
						stat_q   <= (lf_ge_used && full) ? STAT_FULL : STAT_OK;
						res_q    <= lf_ge_used ? (full ? '0 : used_q) : lf_q;
						p_q      <= CW'(lf_q + CW'(1));
						dir_up_q <= 1'b1;
						trim_q   <= 1'b0;
						tgt_q    <= FREE_TAG;
					end
					CMD_FREE: begin
						stat_q   <= (!slot_zero && slot_oor) ? STAT_RANGE : STAT_OK;
						res_q    <= '0;
						p_q      <= slot_c;
						dir_up_q <= 1'b0;
						trim_q   <= 1'b1;
						tgt_q    <= FREE_TAG;
					end
					CMD_NEXT: begin
						stat_q   <= STAT_OK;
						res_q    <= off;
						p_q      <= CW'(off + CW'(1));
						dir_up_q <= 1'b1;
						trim_q   <= 1'b0;
						tgt_q    <= req_q.kind;
					end
					default: begin
						stat_q   <= STAT_OK;
						res_q    <= off;
						p_q      <= off;
						dir_up_q <= 1'b0;
						trim_q   <= 1'b0;
						tgt_q    <= req_q.kind;
					end
				endcase
			end
			ST_SCAN: begin
				if (hit && ((req_q.cmd == CMD_NEXT) || (req_q.cmd == CMD_PREV))) begin
					res_q <= rd_addr_s1;
				end
				if (ram_re) begin
					p_q        <= dir_up_q ? CW'(p_q + CW'(1)) : pm1;
					rd_addr_s1 <= issue_addr;
				end
			end
			ST_FIN: begin
				if (rsp_load) begin
					rsp_q.result_slot <= res_x[SLOT_W-1:0];
					rsp_q.status      <= stat_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_x     = XW'(res_q);
	assign req_ready = state_q == ST_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// between items the pointer never sits above the used count
	a_lf_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (lf_q <= used_q))
		else $error("lowest-free pointer above used count");

	// the used count never exceeds the table size
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(SLOTS))
		else $error("used count beyond table size");

	// RAM reads are only in flight while scanning
	a_rd_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> $past(state_q == ST_SCAN))
		else $error("tag read outside a scan");

	// a new response beat only ever comes from the finishing step
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FIN))
		else $error("response raised outside finish");
`endif

endmodule
